// ===== src/fstrm_pkg.sv =====
// ---------------------------------------------------------------------------
// fstrm_pkg: shared types and constants of the slot table rate meter
// Opcodes, status codes, register indexes and the per-slot record layout.
// ---------------------------------------------------------------------------
package fstrm_pkg;

   localparam int unsigned SLOT_COUNT_DEF = 512;

   localparam int unsigned SESS_W = 64;
   localparam int unsigned TIME_W = 48;
   localparam int unsigned BYTES_W = 64;
   localparam int unsigned RATE_W = 48;
   localparam int unsigned NUM_W = BYTES_W + 10;  // bytes times 1000
   localparam int unsigned CNT_W = 7;

   localparam logic [2:0] OP_ALLOC = 3'd0;
   localparam logic [2:0] OP_UPDATE = 3'd1;
   localparam logic [2:0] OP_SET_STATE = 3'd2;
   localparam logic [2:0] OP_COUNT = 3'd3;
   localparam logic [2:0] OP_FREE = 3'd4;
   localparam logic [2:0] OP_FREE_SESS = 3'd5;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_IGNORED = 2'd2;

   localparam logic [1:0] REG_WINDOW = 2'd0;
   localparam logic [1:0] REG_ACTIVE = 2'd1;
   localparam logic [1:0] REG_CLOSING = 2'd2;

   localparam logic [15:0] WINDOW_RST = 16'd1000;
   localparam logic [7:0] ACTIVE_RST = 8'd1;
   localparam logic [7:0] CLOSING_RST = 8'd4;

   typedef struct packed {
      logic                used;
      logic [SESS_W-1:0]   sess_high;
      logic [SESS_W-1:0]   sess_low;
      logic [TIME_W-1:0]   last_sample;
      logic [BYTES_W-1:0]  total;
      logic [BYTES_W-1:0]  at_sample;
      logic [RATE_W-1:0]   rate;
   } rec_type;

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_CLEAR = 9'b000000010,
      S_READ  = 9'b000000100,
      S_EXAM  = 9'b000001000,
      S_UPD   = 9'b000010000,
      S_MUL   = 9'b000100000,
      S_DIV   = 9'b001000000,
      S_FOLD  = 9'b010000000,
      S_DONE  = 9'b100000000
   } state_type;

endpackage

// ===== src/flow_slot_table_rate_meter_top.sv =====
// ---------------------------------------------------------------------------
// flow_slot_table_rate_meter_top: transfer slot table with rate meter
// One record memory scanned one slot at a time, and a bit-serial divider.
// ---------------------------------------------------------------------------
// Items are handled one at a time. After reset a clearing pass over all
// SLOT_COUNT slots runs before the first item is taken. A slot is read in
// S_READ (registered memory read), then checked in S_EXAM; alloc scans up
// to the first free slot and free session scans all slots. Set state, count
// op and free slot pass S_READ, S_EXAM and S_DONE, an update without a rate
// sample adds S_UPD, and one that folds in a sample adds S_FOLD, after
// S_MUL (times 1000) and S_DIV (one-bit-a-cycle divider for bytes*1000/dt)
// when bytes came in. Each item gives one response.
module flow_slot_table_rate_meter_top #(
   parameter int unsigned SLOT_COUNT = fstrm_pkg::SLOT_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_opcode,
   input  logic [8:0]  req_slot_number,
   input  logic [63:0] req_in_session_low,
   input  logic [63:0] req_in_session_high,
   input  logic [7:0]  req_direction_code,
   input  logic [7:0]  req_protocol_code,
   input  logic signed [48:0] req_expected_size,
   input  logic [47:0] req_now_ms,
   input  logic signed [31:0] req_byte_count,
   input  logic [7:0]  req_new_state,
   input  logic [2:0]  req_op_class,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [8:0]  rsp_result_slot,
   output logic [31:0] rsp_result_serial,
   output logic [47:0] rsp_rate_bps,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int unsigned IDX_W = $clog2(SLOT_COUNT);
   localparam int unsigned TW = fstrm_pkg::TIME_W;
   localparam int unsigned BW = fstrm_pkg::BYTES_W;
   localparam int unsigned RW = fstrm_pkg::RATE_W;
   localparam int unsigned NW = fstrm_pkg::NUM_W;
   localparam int unsigned CW = fstrm_pkg::CNT_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

   fstrm_pkg::rec_type slot_mem_ff [SLOT_COUNT];
   fstrm_pkg::rec_type rd_ff;
   fstrm_pkg::rec_type wr_data;
   logic               wr_en;

   fstrm_pkg::state_type state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [2:0]       op_ff, op_in;
   logic [63:0]      slo_ff, slo_in, shi_ff, shi_in;
   logic [TW-1:0]    now_ff, now_in;
   logic [31:0]      bc_ff, bc_in;
   logic [1:0]       st_ff, st_in;
   logic [8:0]       rslot_ff, rslot_in;
   logic [31:0]      ser_o_ff, ser_o_in;
   logic [RW-1:0]    rate_o_ff, rate_o_in;
   logic [31:0]      serial_ff, serial_in;
   logic [BW-1:0]    tot_ff, tot_in;
   logic [TW-1:0]    dt_ff, dt_in;
   logic [NW-1:0]    num_ff, num_in;
   logic [NW-1:0]    quo_ff, quo_in;
   logic [TW-1:0]    rem_ff, rem_in;
   logic [CW-1:0]    cnt_ff, cnt_in;

   logic             rsp_valid_ff;
   logic [1:0]       rsp_status_ff;
   logic [8:0]       rsp_slot_ff;
   logic [31:0]      rsp_serial_ff;
   logic [RW-1:0]    rsp_rate_ff;

   logic [15:0]      window_ff;
   logic [7:0]       active_ff;
   logic [7:0]       closing_ff;

   // combinational helpers
   logic             slot_ok;
   logic             bc_pos;
   logic [TW-1:0]    dt_now;
   logic [TW-1:0]    win;
   logic [BW-1:0]    diff;
   logic [TW:0]      trial;
   logic [RW-1:0]    raw;
   logic [RW+2:0]    fold_sum;
   logic             rsp_free;

   assign req_ready = (state_ff == fstrm_pkg::S_IDLE);
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign slot_ok = 32'(req_slot_number) < 32'(SLOT_COUNT);
   assign bc_pos = !bc_ff[31] && (bc_ff != 32'd0);
   assign dt_now = now_ff - rd_ff.last_sample;
   assign win = (window_ff == 16'd0) ? TW'(1) : TW'(window_ff);
   assign diff = tot_ff - rd_ff.at_sample;
   assign trial = {rem_ff, num_ff[NW-1]};
   assign raw = (|quo_ff[NW-1:RW]) ? {RW{1'b1}} : quo_ff[RW-1:0];
   assign fold_sum = (RW+3)'(raw) + (RW+3)'(rd_ff.rate) + ((RW+3)'(rd_ff.rate) << 1);

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      op_in = op_ff;
      slo_in = slo_ff;
      shi_in = shi_ff;
      now_in = now_ff;
      bc_in = bc_ff;
      st_in = st_ff;
      rslot_in = rslot_ff;
      ser_o_in = ser_o_ff;
      rate_o_in = rate_o_ff;
      serial_in = serial_ff;
      tot_in = tot_ff;
      dt_in = dt_ff;
      num_in = num_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      wr_en = 1'b0;
      wr_data = rd_ff;
      case (state_ff)
         fstrm_pkg::S_IDLE: begin
            if (req_valid) begin
               op_in = req_opcode;
               slo_in = req_in_session_low;
               shi_in = req_in_session_high;
               now_in = req_now_ms;
               bc_in = req_byte_count;
               st_in = fstrm_pkg::ST_OK;
               rslot_in = req_slot_number;
               ser_o_in = 32'd0;
               rate_o_in = '0;
               if (req_opcode == fstrm_pkg::OP_ALLOC
                   || req_opcode == fstrm_pkg::OP_FREE_SESS) begin
                  idx_in = '0;
                  state_in = fstrm_pkg::S_READ;
               end else if (req_opcode > fstrm_pkg::OP_FREE_SESS || !slot_ok) begin
                  st_in = fstrm_pkg::ST_IGNORED;
                  state_in = fstrm_pkg::S_DONE;
               end else begin
                  idx_in = IDX_W'(req_slot_number);
                  state_in = fstrm_pkg::S_READ;
               end
            end
         end
         fstrm_pkg::S_CLEAR: begin
            wr_en = 1'b1;
            wr_data = '0;
            if (idx_ff == LAST_IDX) begin
               state_in = fstrm_pkg::S_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         fstrm_pkg::S_READ: begin
            state_in = fstrm_pkg::S_EXAM;
         end
         fstrm_pkg::S_EXAM: begin
            case (op_ff)
               fstrm_pkg::OP_ALLOC: begin
                  if (!rd_ff.used) begin
                     wr_en = 1'b1;
                     wr_data = '0;
                     wr_data.used = 1'b1;
                     wr_data.sess_low = slo_ff;
                     wr_data.sess_high = shi_ff;
                     serial_in = serial_ff + 32'd1;
                     ser_o_in = serial_ff + 32'd1;
                     rslot_in = 9'(idx_ff);
                     state_in = fstrm_pkg::S_DONE;
                  end else if (idx_ff == LAST_IDX) begin
                     st_in = fstrm_pkg::ST_FULL;
                     rslot_in = 9'd0;
                     state_in = fstrm_pkg::S_DONE;
                  end else begin
                     idx_in = idx_ff + 1'b1;
                     state_in = fstrm_pkg::S_READ;
                  end
               end
               fstrm_pkg::OP_FREE_SESS: begin
                  if (rd_ff.used && rd_ff.sess_low == slo_ff && rd_ff.sess_high == shi_ff) begin
                     wr_en = 1'b1;
                     wr_data.used = 1'b0;
                  end
                  if (idx_ff == LAST_IDX) begin
                     rslot_in = 9'd0;
                     state_in = fstrm_pkg::S_DONE;
                  end else begin
                     idx_in = idx_ff + 1'b1;
                     state_in = fstrm_pkg::S_READ;
                  end
               end
               fstrm_pkg::OP_FREE: begin
                  wr_en = 1'b1;
                  wr_data.used = 1'b0;
                  state_in = fstrm_pkg::S_DONE;
               end
               fstrm_pkg::OP_UPDATE: begin
                  if (!rd_ff.used) begin
                     st_in = fstrm_pkg::ST_IGNORED;
                     state_in = fstrm_pkg::S_DONE;
                  end else begin
                     tot_in = rd_ff.total + (bc_pos ? BW'(bc_ff) : BW'(0));
                     state_in = fstrm_pkg::S_UPD;
                  end
               end
               default: begin
                  if (!rd_ff.used) begin
                     st_in = fstrm_pkg::ST_IGNORED;
                  end
                  state_in = fstrm_pkg::S_DONE;
               end
            endcase
         end
         fstrm_pkg::S_UPD: begin
            rate_o_in = rd_ff.rate;
            if (rd_ff.last_sample == '0) begin
               // first update only seeds the window
               wr_en = 1'b1;
               wr_data.last_sample = now_ff;
               wr_data.total = tot_ff;
               wr_data.at_sample = tot_ff;
               state_in = fstrm_pkg::S_DONE;
            end else if (now_ff >= rd_ff.last_sample && dt_now >= win) begin
               dt_in = dt_now;
               num_in = NW'(diff);
               quo_in = '0;
               rem_in = '0;
               cnt_in = '0;
               if (diff != '0 && !diff[BW-1]) begin
                  state_in = fstrm_pkg::S_MUL;
               end else begin
                  state_in = fstrm_pkg::S_FOLD;
               end
            end else begin
               wr_en = 1'b1;
               wr_data.total = tot_ff;
               state_in = fstrm_pkg::S_DONE;
            end
         end
         fstrm_pkg::S_MUL: begin
            // times 1000 as 1024 - 16 - 8
            num_in = (num_ff << 10) - (num_ff << 4) - (num_ff << 3);
            state_in = fstrm_pkg::S_DIV;
         end
         fstrm_pkg::S_DIV: begin
            if (trial >= {1'b0, dt_ff}) begin
               rem_in = TW'(trial - {1'b0, dt_ff});
               quo_in = {quo_ff[NW-2:0], 1'b1};
            end else begin
               rem_in = trial[TW-1:0];
               quo_in = {quo_ff[NW-2:0], 1'b0};
            end
            num_in = num_ff << 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(NW - 1)) begin
               state_in = fstrm_pkg::S_FOLD;
            end
         end
         fstrm_pkg::S_FOLD: begin
            wr_en = 1'b1;
            wr_data.last_sample = now_ff;
            wr_data.total = tot_ff;
            wr_data.at_sample = tot_ff;
            wr_data.rate = fold_sum[RW+1:2];
            rate_o_in = fold_sum[RW+1:2];
            state_in = fstrm_pkg::S_DONE;
         end
         fstrm_pkg::S_DONE: begin
            if (rsp_free) begin
               state_in = fstrm_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = fstrm_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem_ff[idx_ff] <= wr_data;
      end
      rd_ff <= slot_mem_ff[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fstrm_pkg::S_CLEAR;
         idx_ff <= '0;
         serial_ff <= 32'd0;
         rsp_valid_ff <= 1'b0;
         window_ff <= fstrm_pkg::WINDOW_RST;
         active_ff <= fstrm_pkg::ACTIVE_RST;
         closing_ff <= fstrm_pkg::CLOSING_RST;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         serial_ff <= serial_in;
         if (state_ff == fstrm_pkg::S_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (psel && penable && pwrite) begin
            case (paddr[3:2])
               fstrm_pkg::REG_WINDOW: window_ff <= pwdata[15:0];
               fstrm_pkg::REG_ACTIVE: active_ff <= pwdata[7:0];
               fstrm_pkg::REG_CLOSING: closing_ff <= pwdata[7:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      slo_ff <= slo_in;
      shi_ff <= shi_in;
      now_ff <= now_in;
      bc_ff <= bc_in;
      st_ff <= st_in;
      rslot_ff <= rslot_in;
      ser_o_ff <= ser_o_in;
      rate_o_ff <= rate_o_in;
      tot_ff <= tot_in;
      dt_ff <= dt_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (state_ff == fstrm_pkg::S_DONE && rsp_free) begin
         rsp_status_ff <= st_ff;
         rsp_slot_ff <= rslot_ff;
         rsp_serial_ff <= ser_o_ff;
         rsp_rate_ff <= rate_o_ff;
      end
   end

   always_comb begin
      case (paddr[3:2])
         fstrm_pkg::REG_WINDOW: prdata = {16'd0, window_ff};
         fstrm_pkg::REG_ACTIVE: prdata = {24'd0, active_ff};
         fstrm_pkg::REG_CLOSING: prdata = {24'd0, closing_ff};
         default: prdata = 32'd0;
      endcase
   end

   assign pready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_result_slot = rsp_slot_ff;
   assign rsp_result_serial = rsp_serial_ff;
   assign rsp_rate_bps = rsp_rate_ff;

   // input beats not consumed by the sequencer
   logic unused_ok;
   assign unused_ok = ^{req_direction_code, req_protocol_code, req_expected_size,
                        req_new_state, req_op_class};

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("accepted a second beat while busy");

   a_no_ready_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !req_ready)
      else $error("ready during clearing pass");

   a_full_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == fstrm_pkg::ST_FULL) |-> rsp_result_slot == 9'd0)
      else $error("table full response with nonzero slot");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fstrm_pkg::S_DIV) |-> cnt_ff < CW'(NW))
      else $error("divider ran past its width");

endmodule
